@@ rtl/core/smoothed_point_follower_heading_core_defines.svh @@
// Assertion macros shared by the core. They expect clk and rst in scope.
`ifndef SMOOTHED_POINT_FOLLOWER_HEADING_CORE_DEFINES_SVH
`define SMOOTHED_POINT_FOLLOWER_HEADING_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SPHD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sphd same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SPHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sphd next-cycle check failed");

`endif

@@ rtl/core/sphd_pkg.sv @@
package sphd_pkg;

  localparam int TGT_W      = 16;
  localparam int POS_W      = 32;
  localparam int GAP_W      = 33;
  localparam int RATE_W     = 16;
  localparam int PROD_W     = 50;
  localparam int STEP_W     = 34;
  localparam int SUM_W      = 35;
  localparam int HEAD_W     = 16;
  localparam int CW         = 45;
  localparam int ACC_W      = 26;
  localparam int ATAN_DEPTH = 24;
  localparam int ITER_CNT_W = 5;
  localparam int QDEPTH     = 2;

  localparam int ANGLE_ITERATIONS_DEF = 16;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_CATCH_UP_RATE = '0;
  localparam logic [RATE_W-1:0] CATCH_UP_RATE_RST = 16'd1966;

  // Quarter turn in 1/256 heading units.
  localparam logic signed [ACC_W-1:0] ACC_QUARTER = 26'sd4194304;

  typedef struct packed {
    logic signed [POS_W-1:0] nx;
    logic signed [POS_W-1:0] ny;
    logic signed [GAP_W-1:0] dx;
    logic signed [GAP_W-1:0] dy;
  } sphd_move_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sphd_qstat_t;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_UPD} sphd_front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_NORM, B_ITER, B_DONE} sphd_back_state_t;

  // atan(2^-i) in 1/256 heading units.
  function automatic logic signed [ACC_W-1:0] atan_lookup(input logic [ITER_CNT_W-1:0] i);
    logic signed [ACC_W-1:0] r;
    r = '0;
    case (i)
      5'd0:    r = 26'sd2097152;
      5'd1:    r = 26'sd1238021;
      5'd2:    r = 26'sd654136;
      5'd3:    r = 26'sd332050;
      5'd4:    r = 26'sd166669;
      5'd5:    r = 26'sd83416;
      5'd6:    r = 26'sd41718;
      5'd7:    r = 26'sd20860;
      5'd8:    r = 26'sd10430;
      5'd9:    r = 26'sd5215;
      5'd10:   r = 26'sd2608;
      5'd11:   r = 26'sd1304;
      5'd12:   r = 26'sd652;
      5'd13:   r = 26'sd326;
      5'd14:   r = 26'sd163;
      5'd15:   r = 26'sd81;
      5'd16:   r = 26'sd41;
      5'd17:   r = 26'sd20;
      5'd18:   r = 26'sd10;
      5'd19:   r = 26'sd5;
      5'd20:   r = 26'sd3;
      5'd21:   r = 26'sd1;
      5'd22:   r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/sphd_front.sv @@
module sphd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [sphd_pkg::RATE_W-1:0]  rate,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // target_x [15:0], target_y [31:16]
  input  sphd_pkg::sphd_qstat_t        qstat,
  output logic                         push,
  output sphd_pkg::sphd_move_t         push_data
);
  import sphd_pkg::*;

  sphd_front_state_t state, state_next;

  logic signed [POS_W-1:0]  pos_x, pos_y;
  logic signed [TGT_W-1:0]  tx, ty;
  logic signed [PROD_W-1:0] prod_x, prod_y;

  logic signed [GAP_W-1:0]  gap_x, gap_y;
  logic signed [RATE_W:0]   rate_s;
  logic signed [PROD_W-1:0] rnd_x, rnd_y;
  logic signed [STEP_W-1:0] step_x, step_y;
  logic signed [SUM_W-1:0]  sum_x, sum_y;
  logic signed [POS_W-1:0]  nx, ny;

  function automatic logic signed [POS_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [POS_W-1:0] r;
    r = v[POS_W-1:0];
    if (v[SUM_W-1:POS_W-1] != '0 && v[SUM_W-1:POS_W-1] != '1) begin
      r = v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  always_comb begin
    rate_s = $signed({1'b0, rate});
    gap_x  = GAP_W'($signed({tx, 16'b0})) - GAP_W'(pos_x);
    gap_y  = GAP_W'($signed({ty, 16'b0})) - GAP_W'(pos_y);
    rnd_x  = prod_x + PROD_W'(32768);
    rnd_y  = prod_y + PROD_W'(32768);
    step_x = rnd_x[PROD_W-1:16];
    step_y = rnd_y[PROD_W-1:16];
    sum_x  = SUM_W'(pos_x) + SUM_W'(step_x);
    sum_y  = SUM_W'(pos_y) + SUM_W'(step_y);
    nx     = sat(sum_x);
    ny     = sat(sum_y);
    push_data.nx = nx;
    push_data.ny = ny;
    push_data.dx = GAP_W'(nx) - GAP_W'(pos_x);
    push_data.dy = GAP_W'(ny) - GAP_W'(pos_y);
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    push          = 1'b0;
    unique case (state)
      F_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = F_MUL;
      end
      F_MUL: state_next = F_UPD;
      F_UPD: begin
        if (!qstat.full) begin
          push       = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      pos_x <= '0;
      pos_y <= '0;
    end else begin
      state <= state_next;
      if (push) begin
        pos_x <= nx;
        pos_y <= ny;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tx <= s_axis_tdata[15:0];
      ty <= s_axis_tdata[31:16];
    end
    if (state == F_MUL) begin
      prod_x <= PROD_W'(gap_x) * PROD_W'(rate_s);
      prod_y <= PROD_W'(gap_y) * PROD_W'(rate_s);
    end
  end

endmodule

@@ rtl/core/sphd_queue.sv @@
module sphd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  sphd_pkg::sphd_move_t  push_data,
  input  logic                  pop,
  output sphd_pkg::sphd_move_t  pop_data,
  output sphd_pkg::sphd_qstat_t qstat
);
  import sphd_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  sphd_move_t         slots [QDEPTH];
  logic [PTR_W-1:0]   wptr, rptr;
  logic [PTR_W:0]     count;

  assign pop_data    = slots[rptr];
  assign qstat.full  = (count == (PTR_W+1)'(QDEPTH));
  assign qstat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PTR_W'(QDEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == PTR_W'(QDEPTH-1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

endmodule

@@ rtl/core/sphd_back.sv @@
module sphd_back #(
  parameter int ANGLE_ITERATIONS = sphd_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sphd_pkg::sphd_qstat_t qstat,
  input  sphd_pkg::sphd_move_t  pop_data,
  output logic                  pop,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [79:0]           m_axis_tdata   // smoothed_x [31:0], smoothed_y [63:32], heading [79:64]
);
  import sphd_pkg::*;

  localparam int ITER_N = (ANGLE_ITERATIONS < ATAN_DEPTH) ? ANGLE_ITERATIONS : ATAN_DEPTH;
  localparam logic [ITER_CNT_W-1:0] ITER_LAST = ITER_CNT_W'(ITER_N - 1);

  sphd_back_state_t state, state_next;

  logic signed [CW-1:0]     x, y;
  logic signed [ACC_W-1:0]  acc;
  logic [ITER_CNT_W-1:0]    iter;
  logic signed [POS_W-1:0]  nx_r, ny_r;

  logic signed [CW-1:0]     ax, ay, mag, xs, ys;
  logic signed [ACC_W-1:0]  rnd, ang;
  logic                     y_pos, load_out;

  always_comb begin
    ax    = x[CW-1] ? -x : x;
    ay    = y[CW-1] ? -y : y;
    mag   = ax | ay;
    xs    = x >>> iter;
    ys    = y >>> iter;
    y_pos = !y[CW-1] && (y != '0);
    ang   = atan_lookup(iter);
    rnd   = acc + ACC_W'(128);
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          state_next = (pop_data.dx == '0 && pop_data.dy == '0) ? B_DONE : B_NORM;
        end
      end
      B_NORM: if (mag[CW-1:40] != '0) state_next = B_ITER;
      B_ITER: if (iter == ITER_LAST) state_next = B_DONE;
      B_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out)           m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        x    <= CW'(pop_data.dx);
        y    <= CW'(pop_data.dy);
        nx_r <= pop_data.nx;
        ny_r <= pop_data.ny;
        acc  <= '0;
        iter <= '0;
      end
      B_NORM: begin
        // Doubling stops once either magnitude reaches 2^40.
        if (mag[CW-1:33] == '0) begin
          x <= x <<< 8;
          y <= y <<< 8;
        end else if (mag[CW-1:37] == '0) begin
          x <= x <<< 4;
          y <= y <<< 4;
        end else if (mag[CW-1:39] == '0) begin
          x <= x <<< 2;
          y <= y <<< 2;
        end else if (mag[CW-1:40] == '0) begin
          x <= x <<< 1;
          y <= y <<< 1;
        end else if (x[CW-1]) begin
          // Fold the left half-plane onto the right.
          if (!y[CW-1]) begin
            x   <= y;
            y   <= -x;
            acc <= ACC_QUARTER;
          end else begin
            x   <= -y;
            y   <= x;
            acc <= -ACC_QUARTER;
          end
        end
      end
      B_ITER: begin
        if (y_pos) begin
          x   <= x + ys;
          y   <= y - xs;
          acc <= acc + ang;
        end else begin
          x   <= x - ys;
          y   <= y + xs;
          acc <= acc - ang;
        end
        iter <= iter + 1'b1;
      end
      default: ;
    endcase
    if (load_out) m_axis_tdata <= {rnd[23:8], ny_r, nx_r};
  end

endmodule

@@ rtl/core/smoothed_point_follower_heading_core.sv @@
// Smoothed point follower: each input word carries a target point in whole pixels.
// A Q16.16 position moves the fraction catch_up_rate (Q0.16) of the way to it on each
// axis, saturating at the Q16.16 limits, and the output word gives the new position with
// the heading of the step (atan2 of the movement, 32768 = pi, zero movement gives 0).
// The front end works through capture, multiply and update before it takes another word
// (update waits while the queue is full) and parks the move in a two-entry queue; the
// back end runs the heading through an iterative CORDIC unit: a pop step, normalising
// steps that scale the movement up (the last also folds the left half-plane),
// ANGLE_ITERATIONS rotation steps (capped at ATAN_DEPTH) and an output step; a zero
// movement goes from the pop straight to the output. A result waits in the output
// register while the queue keeps the front end going until it fills.
// Configure catch_up_rate at APB address 0 only while no word is in flight.
module smoothed_point_follower_heading_core #(
  parameter int ANGLE_ITERATIONS = sphd_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sphd_pkg::PADDR_W-1:0]  paddr,
  input  logic [sphd_pkg::PDATA_W-1:0]  pwdata,
  output logic [sphd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  // target stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [31:0]                   s_axis_tdata,  // target_x [15:0], target_y [31:16]
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [79:0]                   m_axis_tdata   // smoothed_x, smoothed_y, heading
);
  import sphd_pkg::*;

  `include "smoothed_point_follower_heading_core_defines.svh"

  logic [RATE_W-1:0] catch_up_rate;
  logic              reg_hit;

  sphd_qstat_t qstat;
  sphd_move_t  q_push_data, q_pop_data;
  logic        q_push, q_pop;

  // Registers sit on word boundaries; decode the word index only.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_CATCH_UP_RATE);
  assign prdata  = reg_hit ? PDATA_W'(catch_up_rate) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      catch_up_rate <= CATCH_UP_RATE_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      catch_up_rate <= pwdata[RATE_W-1:0];
    end
  end

  // Front end: smoothing and position update.
  sphd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .rate          (catch_up_rate),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .qstat         (qstat),
    .push          (q_push),
    .push_data     (q_push_data)
  );

  // Hold finished moves until the heading unit is free.
  sphd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .qstat     (qstat)
  );

  // Back end: CORDIC heading and output register.
  sphd_back #(
    .ANGLE_ITERATIONS (ANGLE_ITERATIONS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .qstat         (qstat),
    .pop_data      (q_pop_data),
    .pop           (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `SPHD_ASSERT_NOW(a_queue_no_overflow, q_push, !qstat.full)
  `SPHD_ASSERT_NOW(a_queue_no_underflow, q_pop, !qstat.empty)
  `SPHD_ASSERT_NEXT(a_front_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps

module tb;

  import sphd_pkg::*;

  // One output word: new Q16.16 position and heading of the step.
  typedef struct packed {
    logic [POS_W-1:0]  sx;
    logic [POS_W-1:0]  sy;
    logic [HEAD_W-1:0] hd;
  } track_point_t;

  // Directed row. Where fixed is set the expected word is typed in beside it,
  // otherwise the follower model below supplies it.
  typedef struct packed {
    logic              set_rate;
    logic [RATE_W-1:0] rate;
    logic [TGT_W-1:0]  tx;
    logic [TGT_W-1:0]  ty;
    logic              fixed;
    track_point_t      want;
  } target_row_t;

  localparam int     ROT_STEPS   = (ANGLE_ITERATIONS_DEF < ATAN_DEPTH) ?
                                   ANGLE_ITERATIONS_DEF : ATAN_DEPTH;
  localparam longint NORM_LIMIT  = 64'sd1099511627776;  // 2^40
  localparam int     HOLD_CYCLES = 400;
  localparam int     SETTLE      = 4;
  localparam int     DRAIN       = 60;
  localparam int     PER_PHASE   = 50;

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [31:0]         s_axis_tdata;   // target_x [15:0], target_y [31:16]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [79:0]         m_axis_tdata;   // smoothed_x [31:0], smoothed_y [63:32], heading [79:64]

  // atan(2^-i) in 1/256 heading units (32768 heading units = pi)
  longint arctan_q8 [0:23] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  // Follower model state
  logic [RATE_W-1:0] rate_now;
  longint            pos_x;
  longint            pos_y;

  track_point_t      due_points[$];   // words the block still owes, oldest first
  int                bad_words;
  int                send_idle_pct;
  int                recv_idle_pct;
  bit                hold_req;

  smoothed_point_follower_heading_core uut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Follower model
  // ---------------------------------------------------------------------------

  // Rounded share of the gap closed on one axis: floor((gap*rate + 2^15) / 2^16).
  function automatic longint axis_step(input longint pos, input logic signed [TGT_W-1:0] tgt);
    longint gap;
    longint prod;
    gap  = longint'(tgt) * 65536 - pos;
    prod = gap * longint'({48'd0, rate_now}) + 32768;
    return prod >>> 16;
  endfunction

  function automatic longint clamp_q16(input longint v);
    if (v > 64'sd2147483647)
      return 64'sd2147483647;
    if (v < -64'sd2147483648)
      return -64'sd2147483648;
    return v;
  endfunction

  // Vectoring CORDIC on the movement; zero movement has heading 0.
  function automatic logic [HEAD_W-1:0] step_heading(input longint dx, input longint dy);
    longint x;
    longint y;
    longint t;
    longint xs;
    longint ys;
    longint acc;
    int     n;
    int     i;
    if (dx == 0 && dy == 0)
      return '0;
    x   = dx;
    y   = dy;
    acc = 0;
    // Scale up until one component reaches 2^40
    for (n = 0; n < 48; n++) begin
      if ((x < 0 ? -x : x) >= NORM_LIMIT || (y < 0 ? -y : y) >= NORM_LIMIT)
        break;
      x = x * 2;
      y = y * 2;
    end
    // Fold the left half-plane onto the right with a quarter turn
    if (x < 0) begin
      if (y >= 0) begin
        t   = x;
        x   = y;
        y   = -t;
        acc = 64'sd4194304;
      end else begin
        t   = x;
        x   = -y;
        y   = t;
        acc = -64'sd4194304;
      end
    end
    for (i = 0; i < ROT_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x   = x + ys;
        y   = y - xs;
        acc = acc + arctan_q8[i];
      end else begin
        x   = x - ys;
        y   = y + xs;
        acc = acc - arctan_q8[i];
      end
    end
    // Round half up to whole units; pi wraps to -pi through the truncation
    acc = (acc + 128) >>> 8;
    return acc[HEAD_W-1:0];
  endfunction

  // Advance the model by one target and return the word the block owes for it.
  function automatic track_point_t follow_target(input logic [TGT_W-1:0] tx,
                                                 input logic [TGT_W-1:0] ty);
    longint       nx;
    longint       ny;
    track_point_t p;
    nx   = clamp_q16(pos_x + axis_step(pos_x, tx));
    ny   = clamp_q16(pos_y + axis_step(pos_y, ty));
    p.hd = step_heading(nx - pos_x, ny - pos_y);
    p.sx = nx[POS_W-1:0];
    p.sy = ny[POS_W-1:0];
    pos_x = nx;
    pos_y = ny;
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready at random, with one long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        // Hold ready low long enough for the block to back up into its input
        for (n = 0; n < HOLD_CYCLES; n++) begin
          m_axis_tready <= 1'b0;
          @(negedge clk);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted result word with the oldest one owed
  always @(posedge clk) begin : result_check
    track_point_t got;
    track_point_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.sx = m_axis_tdata[31:0];
      got.sy = m_axis_tdata[63:32];
      got.hd = m_axis_tdata[79:64];
      if (due_points.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("%t: result word with nothing owed: x %0d y %0d heading %0d", $time,
                   $signed(got.sx), $signed(got.sy), $signed(got.hd));
      end else begin
        want = due_points.pop_front();
        if (got.sx !== want.sx || got.sy !== want.sy || got.hd !== want.hd) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%t: expected x %0d y %0d heading %0d, got x %0d y %0d heading %0d",
                     $time, $signed(want.sx), $signed(want.sy), $signed(want.hd),
                     $signed(got.sx), $signed(got.sy), $signed(got.hd));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Target side and register port
  // ---------------------------------------------------------------------------

  // Offer one target word, idling at random first; valid stays high afterwards
  // so that back-to-back words need no gap.
  task automatic push_target(input logic [TGT_W-1:0] tx, input logic [TGT_W-1:0] ty,
                             input bit fixed, input track_point_t fixed_want);
    track_point_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ty, tx};
    do
      @(posedge clk);
    while (!s_axis_tready);
    want = follow_target(tx, ty);
    if (fixed)
      want = fixed_want;
    due_points.push_back(want);
  endtask

  // Drop valid, let every owed word drain, then write catch_up_rate.
  task automatic program_rate(input logic [RATE_W-1:0] r);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (due_points.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {REG_CATCH_UP_RATE, 2'b00};
    pwdata  <= {{(PDATA_W-RATE_W){1'b0}}, r};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    rate_now = r;
  endtask

  // Directed rows: corners of both fields, rate extremes, zero movement and
  // the step straight along -x whose heading of pi wraps to -pi.
  target_row_t plan [0:21] = '{
    // reset rate, target at origin: no movement
    '{1'b0, 16'd0,     16'd0,     16'd0,     1'b1, '{32'd0, 32'd0, 16'd0}},
    // rate zero: position never moves, heading 0
    '{1'b1, 16'd0,     16'h7FFF,  16'h8000,  1'b1, '{32'd0, 32'd0, 16'd0}},
    '{1'b0, 16'd0,     16'h8000,  16'h7FFF,  1'b1, '{32'd0, 32'd0, 16'd0}},
    '{1'b0, 16'd0,     16'hFFFF,  16'hFFFF,  1'b1, '{32'd0, 32'd0, 16'd0}},
    // default rate written back explicitly; along the axes first
    '{1'b1, 16'd1966,  16'd100,   16'd0,     1'b0, '0},
    '{1'b0, 16'd0,     16'hFF9C,  16'd0,     1'b0, '0},   // pure -x step
    '{1'b0, 16'd0,     16'd0,     16'd100,   1'b0, '0},
    '{1'b0, 16'd0,     16'd0,     16'hFF9C,  1'b0, '0},
    '{1'b0, 16'd0,     16'h7FFF,  16'h7FFF,  1'b0, '0},
    '{1'b0, 16'd0,     16'h8000,  16'h8000,  1'b0, '0},
    '{1'b0, 16'd0,     16'h8000,  16'h7FFF,  1'b0, '0},
    '{1'b0, 16'd0,     16'h7FFF,  16'h8000,  1'b0, '0},
    // full rate: jump almost all the way, then settle to no movement
    '{1'b1, 16'hFFFF,  16'h7FFF,  16'h7FFF,  1'b0, '0},
    '{1'b0, 16'd0,     16'h8000,  16'h8000,  1'b0, '0},
    '{1'b0, 16'd0,     16'h8000,  16'h8000,  1'b0, '0},
    '{1'b0, 16'd0,     16'h8000,  16'h8000,  1'b0, '0},
    '{1'b0, 16'd0,     16'h7FFF,  16'h8000,  1'b0, '0},
    // smallest non-zero rate
    '{1'b1, 16'd1,     16'h7FFF,  16'h7FFF,  1'b0, '0},
    '{1'b0, 16'd0,     16'h8000,  16'd0,     1'b0, '0},
    // half rate
    '{1'b1, 16'h8000,  16'd1234,  16'hEF1F,  1'b0, '0},
    '{1'b0, 16'd0,     16'hFFFF,  16'd1,     1'b0, '0},
    '{1'b0, 16'd0,     16'd0,     16'd0,     1'b0, '0}
  };

  // Rates per random phase; the second slot of each idling mode is drawn at random
  logic [RATE_W-1:0] rate_plan [0:11] = '{
    16'hFFFF, 16'd0, 16'd1966, 16'd0,
    16'd1,    16'd0, 16'h8000, 16'd655,
    16'hFFFF, 16'd0, 16'd3277, 16'd1966
  };

  initial begin : stimulus
    int           mode;
    int           k;
    int           roll;
    int           v;
    logic [15:0]  tx;
    logic [15:0]  ty;
    logic [15:0]  r;

    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 1'b0;
    bad_words     = 0;
    rate_now      = CATCH_UP_RATE_RST;
    pos_x         = 0;
    pos_y         = 0;
    send_idle_pct = 19;
    recv_idle_pct = 86;
    tx            = '0;
    ty            = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    foreach (plan[i]) begin
      if (plan[i].set_rate)
        program_rate(plan[i].rate);
      push_target(plan[i].tx, plan[i].ty, plan[i].fixed, plan[i].want);
    end

    // Random part: fast sender/slow receiver, then swapped, then no idling at all
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 19;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 19;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (k = 0; k < 4; k++) begin
        r = (k == 1) ? 16'($urandom_range(65535)) : rate_plan[mode*4 + k];
        program_rate(r);
        // Stall the result side while targets keep coming
        if (mode == 2 && k == 0)
          hold_req = 1'b1;
        repeat (PER_PHASE) begin
          roll = $urandom_range(99);
          if (roll < 15) begin
            // anywhere in the field
            tx = 16'($urandom_range(65535));
            ty = 16'($urandom_range(65535));
          end else if (roll < 25) begin
            // same target again: the step shrinks towards zero
          end else if (roll < 32) begin
            // a corner or axis of the field
            case ($urandom_range(3))
              0: tx = 16'h7FFF;
              1: tx = 16'h8000;
              2: tx = 16'h0000;
              default: tx = 16'hFFFF;
            endcase
            case ($urandom_range(3))
              0: ty = 16'h7FFF;
              1: ty = 16'h8000;
              2: ty = 16'h0000;
              default: ty = 16'hFFFF;
            endcase
          end else begin
            // drift near the last target, as a pointer would
            v  = int'($signed(tx)) + int'($urandom_range(400)) - 200;
            tx = v[15:0];
            v  = int'($signed(ty)) + int'($urandom_range(400)) - 200;
            ty = v[15:0];
          end
          push_target(tx, ty, 1'b0, '0);
        end
      end
    end

    // Drop valid and wait for the block to drain
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (due_points.size() != 0)
      @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (bad_words == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
